FILE: rtl/core/ipu_pkg.sv
// shared constants, codes, state type and control structs of the integer property unit
// depends on nothing; ipu_ctrl, ipu_datapath and the top level take its names through ipu_pkg::

package ipu_pkg;

  // operand width; only the low DATA_WIDTH bits of value are used, read as signed
  localparam int DATA_WIDTH = 32;
  localparam int MAG_W      = DATA_WIDTH - 1;
  localparam int DIV_W      = (MAG_W + 1) / 2 + 1;
  localparam int SQ_W       = 2 * DIV_W;
  localparam int CNT_W      = $clog2(MAG_W);

  localparam int FUNC_W = 3;
  localparam int SIGN_W = 2;
  localparam int NUM_W  = 34;
  localparam int SUM_W  = 7;
  localparam int DIG_W  = 4;

  // floor(t / 10) = (t * RECIP10) >> RECIP_SHIFT, exact for any t below 2**32
  localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;
  localparam int          PROD_W      = MAG_W + 32;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PARITY  = 3'd0,
    FUNC_PRIME   = 3'd1,
    FUNC_PALIN   = 3'd2,
    FUNC_SIGN    = 3'd3,
    FUNC_REVERSE = 3'd4,
    FUNC_DSUM    = 3'd5
  } func_t;

  localparam logic [SIGN_W-1:0] SIGN_ZERO = 2'd0;
  localparam logic [SIGN_W-1:0] SIGN_POS  = 2'd1;
  localparam logic [SIGN_W-1:0] SIGN_NEG  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_PR_TEST,
    ST_PR_DIV,
    ST_PR_CHECK,
    ST_DIG_MUL,
    ST_DIG_ACC,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic prime_quick;
    logic prime_init;
    logic prime_set;
    logic prime_clr;
    logic div_start;
    logic div_step;
    logic div_next;
    logic dig_mul;
    logic dig_acc;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              t_zero;
    logic              q_zero;
    logic              p_lt2;
    logic              p_even;
    logic              sq_gt_p;
    logic              cnt_zero;
    logic              rem_zero;
  } stat_t;

endpackage

FILE: rtl/core/ipu_ctrl.sv
// sequencer of the integer property unit: handshakes and command generation
// depends on ipu_pkg; drives ipu_datapath through cmd_t and reads stat_t

module ipu_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  ipu_pkg::stat_t stat,
  output ipu_pkg::cmd_t  cmd
);

  ipu_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ipu_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ipu_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ipu_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ipu_pkg::ST_DISPATCH;
        end
      end
      ipu_pkg::ST_DISPATCH: begin
        unique case (stat.func) inside
          ipu_pkg::FUNC_PRIME: begin
            if (stat.p_lt2 || stat.p_even) begin
              cmd.prime_quick = 1'b1;
              state_nxt       = ipu_pkg::ST_FINISH;
            end else begin
              cmd.prime_init = 1'b1;
              state_nxt      = ipu_pkg::ST_PR_TEST;
            end
          end
          ipu_pkg::FUNC_PALIN, ipu_pkg::FUNC_REVERSE, ipu_pkg::FUNC_DSUM: begin
            state_nxt = stat.t_zero ? ipu_pkg::ST_FINISH : ipu_pkg::ST_DIG_MUL;
          end
          default: state_nxt = ipu_pkg::ST_FINISH;
        endcase
      end
      ipu_pkg::ST_PR_TEST: begin
        if (stat.sq_gt_p) begin
          cmd.prime_set = 1'b1;
          state_nxt     = ipu_pkg::ST_FINISH;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = ipu_pkg::ST_PR_DIV;
        end
      end
      ipu_pkg::ST_PR_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.cnt_zero) state_nxt = ipu_pkg::ST_PR_CHECK;
      end
      ipu_pkg::ST_PR_CHECK: begin
        if (stat.rem_zero) begin
          cmd.prime_clr = 1'b1;
          state_nxt     = ipu_pkg::ST_FINISH;
        end else begin
          cmd.div_next = 1'b1;
          state_nxt    = ipu_pkg::ST_PR_TEST;
        end
      end
      ipu_pkg::ST_DIG_MUL: begin
        cmd.dig_mul = 1'b1;
        state_nxt   = ipu_pkg::ST_DIG_ACC;
      end
      ipu_pkg::ST_DIG_ACC: begin
        cmd.dig_acc = 1'b1;
        state_nxt   = stat.q_zero ? ipu_pkg::ST_FINISH : ipu_pkg::ST_DIG_MUL;
      end
      ipu_pkg::ST_FINISH: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ipu_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ipu_pkg::ST_IDLE;
    endcase
  end

endmodule

FILE: rtl/core/ipu_datapath.sv
// datapath of the integer property unit: operand registers, serial remainder
// unit for trial division, divide-by-ten digit stepper and result register
// depends on ipu_pkg; commanded by ipu_ctrl

module ipu_datapath (
  input  logic                           clk,
  input  logic [ipu_pkg::FUNC_W-1:0]     in_func,
  input  logic [ipu_pkg::DATA_WIDTH-1:0] in_value,
  input  ipu_pkg::cmd_t                  cmd,
  output ipu_pkg::stat_t                 stat,
  output logic                           out_verdict,
  output logic [ipu_pkg::SIGN_W-1:0]     out_sign_class,
  output logic [ipu_pkg::NUM_W-1:0]      out_number,
  output logic                           out_invalid
);

  localparam int MW = ipu_pkg::MAG_W;
  localparam int DW = ipu_pkg::DIV_W;
  localparam int SW = ipu_pkg::SQ_W;
  localparam int NW = ipu_pkg::NUM_W;

  logic [ipu_pkg::FUNC_W-1:0] func_r;
  logic                       neg_r, zero_r, parity_r, prime_r;
  logic [MW-1:0]              mag_r, t_r, q_r;
  logic [DW-1:0]              d_r, rem_r;
  logic [SW-1:0]              sq_r;
  logic [ipu_pkg::CNT_W-1:0]  cnt_r;
  logic [NW-1:0]              r_r;
  logic [ipu_pkg::SUM_W-1:0]  s_r;

  logic                           out_verdict_r, out_invalid_r;
  logic [ipu_pkg::SIGN_W-1:0]     out_sign_r;
  logic [NW-1:0]                  out_number_r;

  logic                       in_neg;
  logic [MW-1:0]              in_mag;
  logic [DW:0]                rem_sh, rem_diff;
  logic [DW-1:0]              rem_nxt;
  logic [ipu_pkg::PROD_W-1:0] prod;
  logic [MW+3:0]              ten_q, t_diff;
  logic [ipu_pkg::DIG_W-1:0]  digit;
  logic [NW-1:0]              r_nxt;
  logic                       verdict_c, invalid_c;
  logic [ipu_pkg::SIGN_W-1:0] sign_c;
  logic [NW-1:0]              number_c;

  assign in_neg = in_value[ipu_pkg::DATA_WIDTH-1];
  assign in_mag = in_neg ? '0 : in_value[MW-1:0];

  // one quotient bit of mag / d per step, remainder only
  assign rem_sh   = {rem_r, mag_r[cnt_r]};
  assign rem_diff = rem_sh - {1'b0, d_r};
  assign rem_nxt  = (rem_sh >= {1'b0, d_r}) ? rem_diff[DW-1:0] : rem_sh[DW-1:0];

  // quotient by ten through the reciprocal, digit from the registered quotient
  assign prod   = ipu_pkg::PROD_W'(t_r) * ipu_pkg::PROD_W'(ipu_pkg::RECIP10);
  assign ten_q  = {1'b0, q_r, 3'b000} + {3'b000, q_r, 1'b0};
  assign t_diff = {4'b0000, t_r} - ten_q;
  assign digit  = t_diff[ipu_pkg::DIG_W-1:0];
  assign r_nxt  = {r_r[NW-4:0], 3'b000} + {r_r[NW-2:0], 1'b0} + NW'(digit);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r   <= in_func;
      neg_r    <= in_neg;
      zero_r   <= (in_value == '0);
      parity_r <= ~in_value[0];
      mag_r    <= in_mag;
      t_r      <= in_mag;
      r_r      <= '0;
      s_r      <= '0;
    end
    if (cmd.prime_quick) prime_r <= (mag_r == MW'(2));
    if (cmd.prime_set)   prime_r <= 1'b1;
    if (cmd.prime_clr)   prime_r <= 1'b0;
    if (cmd.prime_init) begin
      d_r  <= DW'(3);
      sq_r <= SW'(9);
    end
    if (cmd.div_start) begin
      rem_r <= '0;
      cnt_r <= ipu_pkg::CNT_W'(MW - 1);
    end
    if (cmd.div_step) begin
      rem_r <= rem_nxt;
      cnt_r <= cnt_r - 1'b1;
    end
    // (d+2)^2 = d^2 + 4d + 4
    if (cmd.div_next) begin
      d_r  <= d_r + DW'(2);
      sq_r <= sq_r + SW'({d_r, 2'b00}) + SW'(4);
    end
    if (cmd.dig_mul) q_r <= MW'(prod[ipu_pkg::PROD_W-1:ipu_pkg::RECIP_SHIFT]);
    if (cmd.dig_acc) begin
      t_r <= q_r;
      r_r <= r_nxt;
      s_r <= s_r + ipu_pkg::SUM_W'(digit);
    end
    if (cmd.out_load) begin
      out_verdict_r <= verdict_c;
      out_sign_r    <= sign_c;
      out_number_r  <= number_c;
      out_invalid_r <= invalid_c;
    end
  end

  always_comb begin
    verdict_c = 1'b0;
    sign_c    = ipu_pkg::SIGN_ZERO;
    number_c  = '0;
    invalid_c = 1'b0;
    case (func_r)
      ipu_pkg::FUNC_PARITY:  verdict_c = parity_r;
      ipu_pkg::FUNC_PRIME:   verdict_c = prime_r;
      ipu_pkg::FUNC_PALIN:   verdict_c = !neg_r && (NW'(mag_r) == r_r);
      ipu_pkg::FUNC_SIGN:    sign_c = zero_r ? ipu_pkg::SIGN_ZERO :
                                      (neg_r ? ipu_pkg::SIGN_NEG : ipu_pkg::SIGN_POS);
      ipu_pkg::FUNC_REVERSE: number_c = r_r;
      ipu_pkg::FUNC_DSUM:    number_c = NW'(s_r);
      default:               invalid_c = 1'b1;
    endcase
  end

  assign stat.func     = func_r;
  assign stat.t_zero   = (t_r == '0);
  assign stat.q_zero   = (q_r == '0);
  assign stat.p_lt2    = (mag_r < MW'(2));
  assign stat.p_even   = ~mag_r[0];
  assign stat.sq_gt_p  = (sq_r > SW'(mag_r));
  assign stat.cnt_zero = (cnt_r == '0);
  assign stat.rem_zero = (rem_r == '0);

  assign out_verdict    = out_verdict_r;
  assign out_sign_class = out_sign_r;
  assign out_number     = out_number_r;
  assign out_invalid    = out_invalid_r;

endmodule

FILE: rtl/core/integer_property_unit.sv
// integer property unit: parity, sign and unknown codes go from dispatch straight to finish
// digit ops (palindrome, reverse, digit sum): a multiply step and an accumulate step for each decimal digit
// prime: trial division by odd divisors up to sqrt(value), each divisor run through the
// one-bit-a-step remainder unit; even values and values below 2 skip the divisor loop
// one item at a time; a finished result waits in the output register while the next item runs
// reset (rst_n low, synchronous): sequencer idle, no result pending
// top level; depends on ipu_pkg, ipu_ctrl and ipu_datapath

module integer_property_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [7:0]  in_tuser,   // [2:0] func, rest unused
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [0] verdict, [2:1] sign_class, [36:3] number, [39:37] zero
  output logic [7:0]  out_tuser   // [0] invalid, rest zero
);

  ipu_pkg::cmd_t  cmd;
  ipu_pkg::stat_t stat;

  logic                       verdict, invalid;
  logic [ipu_pkg::SIGN_W-1:0] sign_class;
  logic [ipu_pkg::NUM_W-1:0]  number;

  // sequencer: handshakes, dispatch on func, trial-division and digit loops
  ipu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: operand in low DATA_WIDTH bits of tdata
  ipu_datapath u_dp (
    .clk            (clk),
    .in_func        (in_tuser[ipu_pkg::FUNC_W-1:0]),
    .in_value       (in_tdata[ipu_pkg::DATA_WIDTH-1:0]),
    .cmd            (cmd),
    .stat           (stat),
    .out_verdict    (verdict),
    .out_sign_class (sign_class),
    .out_number     (number),
    .out_invalid    (invalid)
  );

  // result item packing, lowest field first
  assign out_tdata = {3'b000, number, sign_class, verdict};
  assign out_tuser = {7'b0000000, invalid};

endmodule

FILE: rtl/core/ipu_checker.sv
// port-level checks for the integer property unit, bound to the top level
// depends only on the ports of integer_property_unit

module ipu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic [7:0]  out_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // one item in flight: input closes right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item accepted while busy");

  // unknown code clears every other field
  a_invalid_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == 40'd0)
    else $error("invalid item with non-zero data");

  // sign class never takes the unused code
  a_sign_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:1] != 2'b11)
    else $error("bad sign class");

  // no result pending after reset
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind integer_property_unit ipu_checker u_ipu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
